>>> rtl/core/hnm_pkg.sv
// Shared types, constants and the header name table of the header name matcher.
`default_nettype none
package hnm_pkg;

  localparam int NAME_COUNT   = 19;
  localparam int MAX_NAME_LEN = 20;
  localparam int POS_W        = 5;
  localparam int CODE_W       = 5;

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] DASH_CHAR  = 8'h2D;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  localparam logic [CODE_W-1:0]     CODE_INVALID   = '0;
  localparam logic [CODE_W-1:0]     CODE_LAST      = CODE_W'(NAME_COUNT);
  localparam logic [POS_W-1:0]      POS_MAX        = '1;
  localparam logic [NAME_COUNT-1:0] ALL_CANDIDATES = '1;

  typedef logic [NAME_COUNT-1:0] cand_mask_t;
  typedef logic [CODE_W-1:0]     code_t;
  typedef logic [POS_W-1:0]      pos_t;

  // Outcome of matching one byte against the open candidates.
  typedef struct packed {
    logic       decided;    // the byte settles the name: a result is due
    code_t      code;       // header code, invalid when no colon matched
    cand_mask_t next_mask;  // candidates that survive the byte
    cand_mask_t colon_hits; // candidates completed by a colon
  } hnm_step_t;

  // Names are stored right-justified; the final colon sits in the low byte.
  localparam logic [8*MAX_NAME_LEN-1:0] NAME_TEXT [NAME_COUNT] = '{
    "AUTHORIZATION:",
    "ACCEPT:",
    "ACCEPT-CHARSET:",
    "ACCEPT-ENCODING:",
    "ACCEPT-LANGUAGE:",
    "EXPECT:",
    "FROM:",
    "HOST:",
    "IF-MATCH:",
    "IF-MODIFIED-SINCE:",
    "IF-NONE-MATCH:",
    "IF-RANGE:",
    "IF-UNMODIFIED-SINCE:",
    "MAX-FORWARDS:",
    "PROXY-AUTHORIZATION:",
    "RANGE:",
    "REFERER:",
    "TE:",
    "USER-AGENT:"
  };

  localparam logic [POS_W-1:0] NAME_LEN [NAME_COUNT] = '{
    5'd14, 5'd7, 5'd15, 5'd16, 5'd16, 5'd7, 5'd5, 5'd5, 5'd9, 5'd18,
    5'd14, 5'd9, 5'd20, 5'd13, 5'd20, 5'd6, 5'd8, 5'd3, 5'd11
  };

  // Character of a name at a position; only meaningful below the name length.
  function automatic logic [7:0] name_char(input int idx, input pos_t pos);
    logic [POS_W-1:0] sel;
    sel = NAME_LEN[idx] - 5'd1 - pos;
    return NAME_TEXT[idx][{sel, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/hnm_match.sv
// Compares one header byte against every still-open candidate name in parallel.
`default_nettype none
module hnm_match
  import hnm_pkg::*;
(
  input  wire logic [7:0] name_byte,
  input  wire pos_t       pos,
  input  wire cand_mask_t mask,
  output hnm_step_t       step
);

  logic [7:0] upper_byte;
  logic       is_colon;
  cand_mask_t hits;

  always_comb begin
    if (name_byte >= LOWER_A && name_byte <= LOWER_Z) begin
      upper_byte = name_byte - CASE_DELTA;
    end else begin
      upper_byte = name_byte;
    end
  end

  assign is_colon = (upper_byte == COLON_CHAR);

  always_comb begin
    for (int k = 0; k < NAME_COUNT; k++) begin
      hits[k] = mask[k] && (pos < NAME_LEN[k]) && (name_char(k, pos) == upper_byte);
    end
  end

  // Names are distinct, so a colon completes at most one of them.
  always_comb begin
    step.code = CODE_INVALID;
    for (int k = NAME_COUNT - 1; k >= 0; k--) begin
      if (is_colon && hits[k]) begin
        step.code = CODE_W'(k + 1);
      end
    end
    step.colon_hits = is_colon ? hits : '0;
    step.next_mask  = is_colon ? '0 : hits;
    step.decided    = is_colon || (hits == '0);
  end

endmodule
`default_nettype wire

>>> rtl/core/http_request_header_name_matcher_core.sv
// Top level of the HTTP request header name matcher.
`default_nettype none
// Recognizes HTTP request header names fed one byte per transfer, with
// in_first_byte marking the first byte of each name. Letters match without
// regard to case, '-' and ':' exactly. One result per name: the header code
// (1 to 19) when the closing colon completes a known name, or 0 when a byte
// rules out every name. Bytes after a decision are dropped until the next
// marked first byte; a marked first byte mid-name restarts without a result.
// One byte is taken per clock while in_stall is low. A byte is captured in an
// input register and matched in the following cycle, and a result is held in
// the output register that drives out_header_code. in_stall rises only when a
// matched byte that decides a name finds the output register still held by
// out_stall; bytes that decide nothing keep flowing meanwhile.
module http_request_header_name_matcher_core
  import hnm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_name_byte,
  input  wire logic       in_first_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [4:0]      out_header_code
);

  // Input register.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] byte_r;
  logic       first_r;

  // Matching state.
  pos_t       pos_r, pos_nxt;
  cand_mask_t mask_r, mask_nxt;
  logic       active_r, active_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  code_t      code_r;

  pos_t       eff_pos;
  cand_mask_t eff_mask;
  logic       eff_active;
  hnm_step_t  step;
  logic       has_result;
  logic       out_free;
  logic       consume;

  assign eff_pos    = first_r ? '0 : pos_r;
  assign eff_mask   = first_r ? ALL_CANDIDATES : mask_r;
  assign eff_active = first_r || active_r;

  hnm_match u_match (
    .name_byte (byte_r),
    .pos       (eff_pos),
    .mask      (eff_mask),
    .step      (step)
  );

  assign has_result = in_valid_r && eff_active && step.decided;
  assign out_free   = !out_valid_r || !out_stall;
  assign consume    = in_valid_r && (!has_result || out_free);
  assign in_stall   = in_valid_r && !consume;

  always_comb begin
    pos_nxt    = pos_r;
    mask_nxt   = mask_r;
    active_nxt = active_r;
    if (consume && eff_active) begin
      if (step.decided) begin
        pos_nxt    = eff_pos;
        mask_nxt   = '0;
        active_nxt = 1'b0;
      end else begin
        pos_nxt    = (eff_pos == POS_MAX) ? eff_pos : eff_pos + 5'd1;
        mask_nxt   = step.next_mask;
        active_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      pos_r       <= '0;
      mask_r      <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      pos_r       <= pos_nxt;
      mask_r      <= mask_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_r  <= in_name_byte;
      first_r <= in_first_byte;
    end
    if (out_free && has_result) begin
      code_r <= step.code;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_header_code = code_r;

  // An open name always has at least one candidate left; an idle one has none.
  a_mask_tracks_active: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r == (mask_r != '0)))
    else $error("candidate mask disagrees with the active flag");

  a_code_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (code_r <= CODE_LAST))
    else $error("header code out of range");

  a_single_colon_hit: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |-> $onehot0(step.colon_hits))
    else $error("colon completed more than one name");

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (has_result && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

>>> bench/tb_http_request_header_name_matcher_core.sv
// Testbench for the HTTP request header name matcher core.
`timescale 1ns / 1ps
module tb_http_request_header_name_matcher_core;
  import hnm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 90;
  localparam int DRAIN_CYCLES = 6;
  localparam int ITEM_TARGET  = 1150;
  localparam logic [6:0] STALL_PATTERN = 7'b0110100;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_name_byte = 8'h00;
  logic       in_first_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_header_code;

  http_request_header_name_matcher_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_name_byte(in_name_byte),
    .in_first_byte(in_first_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_header_code(out_header_code)
  );

  string hdr_names [NAME_COUNT] = '{
    "AUTHORIZATION:", "ACCEPT:", "ACCEPT-CHARSET:", "ACCEPT-ENCODING:",
    "ACCEPT-LANGUAGE:", "EXPECT:", "FROM:", "HOST:", "IF-MATCH:",
    "IF-MODIFIED-SINCE:", "IF-NONE-MATCH:", "IF-RANGE:", "IF-UNMODIFIED-SINCE:",
    "MAX-FORWARDS:", "PROXY-AUTHORIZATION:", "RANGE:", "REFERER:", "TE:",
    "USER-AGENT:"
  };

  // Matcher state as seen by the predictor.
  pos_t       hn_pos = '0;
  cand_mask_t hn_cand = '0;
  logic       hn_open = 1'b0;

  code_t      pending_codes [$];
  code_t      want_code;
  logic [7:0] name_buf [$];
  int         errors = 0;
  int         bytes_fed = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         gap_max = 3;
  int         hold_requests = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         rx_cycle = 0;
  int         rx_mode = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Works out whether a byte decides the open name, and the code it yields.
  function automatic bit decide_header_byte(input logic [7:0] raw, input logic first,
                                            output code_t code);
    logic [7:0] b;
    cand_mask_t survivors;
    code_t      done;
    b = raw;
    survivors = '0;
    done = CODE_INVALID;
    code = CODE_INVALID;
    if (first) begin
      hn_pos = '0;
      hn_cand = '1;
      hn_open = 1'b1;
    end
    if (!hn_open) return 1'b0;
    if (b >= LOWER_A && b <= LOWER_Z) b = b - CASE_DELTA;
    for (int k = 0; k < NAME_COUNT; k++) begin
      if (hn_cand[k] && hn_pos < hdr_names[k].len() && hdr_names[k][hn_pos] == b) begin
        if (b == COLON_CHAR) begin
          if (done == CODE_INVALID) done = code_t'(k + 1);
        end else begin
          survivors[k] = 1'b1;
        end
      end
    end
    if (done != CODE_INVALID || survivors == '0) begin
      hn_open = 1'b0;
      hn_cand = '0;
      code = done;
      return 1'b1;
    end
    hn_cand = survivors;
    if (hn_pos != POS_MAX) hn_pos = hn_pos + 1'b1;
    return 1'b0;
  endfunction

  // Offers one byte, waits for its transfer, records the prediction, then
  // perhaps leaves a gap before the next byte.
  task automatic push_byte(input logic [7:0] b, input logic first);
    code_t code;
    in_valid <= 1'b1;
    in_name_byte <= b;
    in_first_byte <= first;
    do @(posedge clk); while (in_stall);
    bytes_fed++;
    if (decide_header_byte(b, first, code)) pending_codes.push_back(code);
    if (burst_left > 0) begin
      burst_left--;
    end else if (gap_max > 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_name_buf();
    for (int i = 0; i < name_buf.size(); i++) push_byte(name_buf[i], i == 0);
  endtask

  task automatic load_text(input string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endtask

  // Loads a known header name with each letter in random case.
  task automatic load_name(input int idx);
    logic [7:0] c;
    name_buf.delete();
    for (int i = 0; i < hdr_names[idx].len(); i++) begin
      c = hdr_names[idx][i];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + CASE_DELTA;
      name_buf.push_back(c);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Bytes not marked first are dropped while no name is open.
  task automatic test_idle_bytes();
    push_byte(8'hFF, 1'b0);
    push_byte(":", 1'b0);
  endtask

  task automatic test_short_name();
    load_text("tE:");
    send_name_buf();
    push_byte("x", 1'b0);
  endtask

  task automatic test_nul_byte();
    push_byte(8'h00, 1'b1);
    push_byte("h", 1'b1);
    push_byte(8'h00, 1'b0);
  endtask

  // A new first byte while a name is open drops it without a result.
  task automatic test_restart_mid_name();
    push_byte("F", 1'b1);
    push_byte("r", 1'b0);
    load_text("Te:");
    send_name_buf();
  endtask

  task automatic test_other_bytes();
    push_byte(8'hFF, 1'b1);
    push_byte("a", 1'b1);
    push_byte("_", 1'b0);
    push_byte(8'h80, 1'b1);
    load_text("Accept-");
    send_name_buf();
    push_byte(COLON_CHAR, 1'b0);
    wait_all_results();
  endtask

  // The receiver holds off while names keep coming back to back, so the
  // output register fills and the input must stall.
  task automatic test_output_hold();
    gap_max = 0;
    hold_requests++;
    repeat (10) begin
      load_name($urandom_range(0, NAME_COUNT - 1));
      send_name_buf();
    end
    gap_max = 3;
    wait_all_results();
  endtask

  task automatic test_random_traffic(input int target);
    int kind;
    int p;
    int phase_mark;
    phase_mark = bytes_fed;
    while (bytes_fed < target) begin
      if (bytes_fed - phase_mark > 200) begin
        phase_mark = bytes_fed;
        gap_max = $urandom_range(0, 5);
      end
      kind = $urandom_range(0, 99);
      load_name($urandom_range(0, NAME_COUNT - 1));
      if (kind < 55) begin
        // well-formed name, left as loaded
      end else if (kind < 72) begin
        p = $urandom_range(0, name_buf.size() - 1);
        name_buf[p] = 8'($urandom_range(0, 255));
      end else if (kind < 82) begin
        // Truncated name: the next first byte restarts it.
        p = $urandom_range(1, name_buf.size() - 1);
        while (name_buf.size() > p) void'(name_buf.pop_back());
      end else if (kind < 92) begin
        name_buf.delete();
        repeat ($urandom_range(1, 22)) name_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        name_buf.delete();
      end
      if (name_buf.size() != 0) send_name_buf();
      if (kind >= 92 || $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    gap_max = 3;
  endtask

  // Receiver: rotates among no stall, random stalls and a fixed stall pattern, plus a long hold-off on request.
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 35);
        default: out_stall <= STALL_PATTERN[rx_cycle % 7];
      endcase
    end
    if (rx_cycle % 250 == 0) rx_mode = (rx_mode + 1) % 3;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        if (errors < 10) $display("unexpected result: header code %0d", out_header_code);
        errors++;
      end else begin
        want_code = pending_codes.pop_front();
        if (out_header_code !== want_code) begin
          if (errors < 10)
            $display("header code mismatch: expected %0d, got %0d", want_code,
                     out_header_code);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_bytes();
    test_short_name();
    test_nul_byte();
    test_restart_mid_name();
    test_other_bytes();
    test_output_hold();
    test_random_traffic(ITEM_TARGET);
    wait_all_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_codes.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
